// File: hdl/crc64fc_pkg.sv
// Shared types, constants and helpers for the CRC64 fold constant generator.
// No dependencies; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package crc64fc_pkg;

  localparam logic [63:0] POLY_RESET = 64'h42F0_E1EB_A9EA_3693;
  localparam logic [63:0] TOP_BIT    = 64'h8000_0000_0000_0000;

  typedef enum logic [1:0] {
    CMD_FOLD    = 2'd0,
    CMD_BARRETT = 2'd1,
    CMD_RPOLY   = 2'd2,
    CMD_NONE    = 2'd3
  } command_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic step;
    logic emit;
  } dp_ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic count_zero;
  } dp_status_t;

  function automatic logic [63:0] reverse64(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) begin
      r[i] = v[63 - i];
    end
    return r;
  endfunction

endpackage

// File: hdl/crc64fc_ctrl.sv
// Sequencer for the CRC64 fold constant generator: request acceptance,
// step control and the output valid flag. Depends on crc64fc_pkg.
`timescale 1ns / 1ps

module crc64fc_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  logic                    out_ready,
  input  crc64fc_pkg::dp_status_t status,
  output crc64fc_pkg::dp_ctrl_t   ctrl
);

  crc64fc_pkg::state_t state, state_next;
  logic out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= crc64fc_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    ctrl       = '0;
    in_ready   = 1'b0;
    case (state)
      crc64fc_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.load  = 1'b1;
          state_next = crc64fc_pkg::S_RUN;
        end
      end
      crc64fc_pkg::S_RUN: begin
        if (!status.count_zero) begin
          ctrl.step = 1'b1;
        end else if (!out_valid || out_ready) begin
          // hold the finished result until the output register frees up
          ctrl.emit  = 1'b1;
          state_next = crc64fc_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = crc64fc_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end
    if (ctrl.emit) begin
      out_valid_next = 1'b1;
    end
  end

endmodule

// File: hdl/crc64fc_dp.sv
// Datapath for the CRC64 fold constant generator: polynomial register,
// shift-xor step registers, step counter and output register. Uses crc64fc_pkg.
`timescale 1ns / 1ps

module crc64fc_dp #(
  parameter int EXPONENT_BITS = 12
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     polynomial_we,
  input  logic [63:0]              polynomial_wdata,
  input  logic [1:0]               command,
  input  logic [EXPONENT_BITS-1:0] exponent,
  output logic [63:0]              constant,
  input  crc64fc_pkg::dp_ctrl_t    ctrl,
  output crc64fc_pkg::dp_status_t  status
);

  localparam logic [EXPONENT_BITS-1:0] FOLD_BASE = EXPONENT_BITS'(64);
  localparam logic [EXPONENT_BITS-1:0] COUNT_ONE = EXPONENT_BITS'(1);

  logic [63:0]              polynomial;
  logic [63:0]              poly_rev;
  logic [1:0]               cmd;
  logic                     zero_fold;
  logic [EXPONENT_BITS-1:0] count;
  logic [63:0]              n;
  logic [63:0]              lo;
  logic                     hi;
  logic [63:0]              q;
  logic [63:0]              lo_x;
  logic [63:0]              result;

  always_ff @(posedge clk) begin
    if (rst) begin
      polynomial <= crc64fc_pkg::POLY_RESET;
    end else if (polynomial_we) begin
      polynomial <= polynomial_wdata;
    end
  end

  assign lo_x     = hi ? (lo ^ polynomial) : lo;
  assign poly_rev = crc64fc_pkg::reverse64(polynomial);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd       <= command;
      zero_fold <= (exponent <= FOLD_BASE);
      n         <= crc64fc_pkg::TOP_BIT;
      hi        <= 1'b1;
      lo        <= '0;
      q         <= '0;
      case (crc64fc_pkg::command_t'(command))
        crc64fc_pkg::CMD_FOLD:
          count <= (exponent > FOLD_BASE) ? (exponent - FOLD_BASE) : '0;
        crc64fc_pkg::CMD_BARRETT: count <= FOLD_BASE;
        default:                  count <= '0;
      endcase
    end else if (ctrl.step) begin
      count <= count - COUNT_ONE;
      // advance both recurrences; only the one for the stored command is used
      n     <= n[63] ? ({n[62:0], 1'b0} ^ polynomial) : {n[62:0], 1'b0};
      q     <= {q[62:0], hi};
      hi    <= lo_x[63];
      lo    <= {lo_x[62:0], 1'b0};
    end
  end

  always_comb begin
    case (crc64fc_pkg::command_t'(cmd))
      crc64fc_pkg::CMD_FOLD:    result = zero_fold ? '0 : crc64fc_pkg::reverse64(n);
      crc64fc_pkg::CMD_BARRETT: result = crc64fc_pkg::reverse64(q);
      crc64fc_pkg::CMD_RPOLY:   result = {poly_rev[62:0], 1'b1};
      default:                  result = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      constant <= result;
    end
  end

  assign status.count_zero = (count == '0);

endmodule

// File: hdl/crc64_reflected_fold_constant_gen.sv
// Top level of the CRC64 reflected fold constant generator.
// Instantiates crc64fc_ctrl and crc64fc_dp; types from crc64fc_pkg.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    command[1:0], exponent
//   out      output     out_valid / out_ready  constant[63:0]
//   config   input      polynomial_we          polynomial_wdata[63:0]
//
// One request at a time: the step counter drives one shift-xor per cycle.
// Each request loads the step counter, steps until the counter is zero, then emits.
// The result sits in an output register; a new request is taken while it waits.
// A stalled output holds the next finished request before its last cycle.
// Synchronous reset restores the polynomial register to the ECMA-182 value.
`timescale 1ns / 1ps

module crc64_reflected_fold_constant_gen #(
  parameter int EXPONENT_BITS = 12
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     polynomial_we,
  input  logic [63:0]              polynomial_wdata,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               command,
  input  logic [EXPONENT_BITS-1:0] exponent,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [63:0]              constant
);

  crc64fc_pkg::dp_ctrl_t   ctrl;
  crc64fc_pkg::dp_status_t status;

  crc64fc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .ctrl      (ctrl)
  );

  crc64fc_dp #(
    .EXPONENT_BITS (EXPONENT_BITS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .polynomial_we    (polynomial_we),
    .polynomial_wdata (polynomial_wdata),
    .command          (command),
    .exponent         (exponent),
    .constant         (constant),
    .ctrl             (ctrl),
    .status           (status)
  );

endmodule
